@@ rtl/core/tvm_pkg.sv @@
`timescale 1ns / 1ps
package tvm_pkg;

   localparam int unsigned MEM_WORDS = 59049;
   localparam int unsigned WORD_W   = 16;
   localparam int unsigned ADDR_W   = 16;
   localparam int unsigned TRITS    = 10;
   localparam logic [15:0] TRIT_TOP = 16'd19683;
   localparam logic [6:0]  OP_JMP   = 7'd4;
   localparam logic [6:0]  OP_OUT   = 7'd5;
   localparam logic [6:0]  OP_IN    = 7'd23;
   localparam logic [6:0]  OP_ROT   = 7'd39;
   localparam logic [6:0]  OP_MOVD  = 7'd40;
   localparam logic [6:0]  OP_CRZ   = 7'd62;
   localparam logic [6:0]  OP_HLT   = 7'd81;

   localparam logic [1:0] REQ_LOAD    = 2'd0;
   localparam logic [1:0] REQ_EXEC    = 2'd1;
   localparam logic [1:0] REQ_RESTART = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_OUTPUT  = 3'd1;
   localparam logic [2:0] ST_HALTED  = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_LIMIT   = 3'd4;
   localparam logic [2:0] ST_IGNORED = 3'd5;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] addr;
      logic [15:0] word;
      logic [15:0] in_value;
   } req_type_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] out_byte;
      logic       input_taken;
   } rsp_type;

   // reduce a 16-bit value modulo the memory size (value < 2*MEM_WORDS)
   function automatic logic [15:0] mod_mem(input logic [15:0] v);
      logic [16:0] d;
      d = {1'b0, v} - 17'(MEM_WORDS);
      mod_mem = d[16] ? v : d[15:0];
   endfunction

   function automatic logic [6:0] xlat(input logic [6:0] i);
      logic [6:0] r;
      case (i)
         7'd0: r = 7'd53;  7'd1: r = 7'd122; 7'd2: r = 7'd93;  7'd3: r = 7'd38;
         7'd4: r = 7'd103; 7'd5: r = 7'd113; 7'd6: r = 7'd116; 7'd7: r = 7'd121;
         7'd8: r = 7'd102; 7'd9: r = 7'd114; 7'd10: r = 7'd36; 7'd11: r = 7'd40;
         7'd12: r = 7'd119; 7'd13: r = 7'd101; 7'd14: r = 7'd52; 7'd15: r = 7'd123;
         7'd16: r = 7'd87; 7'd17: r = 7'd80; 7'd18: r = 7'd41; 7'd19: r = 7'd72;
         7'd20: r = 7'd45; 7'd21: r = 7'd90; 7'd22: r = 7'd110; 7'd23: r = 7'd44;
         7'd24: r = 7'd91; 7'd25: r = 7'd37; 7'd26: r = 7'd92; 7'd27: r = 7'd51;
         7'd28: r = 7'd100; 7'd29: r = 7'd76; 7'd30: r = 7'd43; 7'd31: r = 7'd81;
         7'd32: r = 7'd59; 7'd33: r = 7'd62; 7'd34: r = 7'd85; 7'd35: r = 7'd33;
         7'd36: r = 7'd112; 7'd37: r = 7'd74; 7'd38: r = 7'd83; 7'd39: r = 7'd55;
         7'd40: r = 7'd50; 7'd41: r = 7'd70; 7'd42: r = 7'd104; 7'd43: r = 7'd79;
         7'd44: r = 7'd65; 7'd45: r = 7'd49; 7'd46: r = 7'd67; 7'd47: r = 7'd66;
         7'd48: r = 7'd54; 7'd49: r = 7'd118; 7'd50: r = 7'd94; 7'd51: r = 7'd61;
         7'd52: r = 7'd73; 7'd53: r = 7'd95; 7'd54: r = 7'd48; 7'd55: r = 7'd47;
         7'd56: r = 7'd56; 7'd57: r = 7'd124; 7'd58: r = 7'd106; 7'd59: r = 7'd115;
         7'd60: r = 7'd98; 7'd61: r = 7'd57; 7'd62: r = 7'd109; 7'd63: r = 7'd60;
         7'd64: r = 7'd46; 7'd65: r = 7'd84; 7'd66: r = 7'd86; 7'd67: r = 7'd97;
         7'd68: r = 7'd99; 7'd69: r = 7'd96; 7'd70: r = 7'd117; 7'd71: r = 7'd89;
         7'd72: r = 7'd42; 7'd73: r = 7'd77; 7'd74: r = 7'd75; 7'd75: r = 7'd39;
         7'd76: r = 7'd88; 7'd77: r = 7'd126; 7'd78: r = 7'd120; 7'd79: r = 7'd68;
         7'd80: r = 7'd108; 7'd81: r = 7'd125; 7'd82: r = 7'd82; 7'd83: r = 7'd69;
         7'd84: r = 7'd111; 7'd85: r = 7'd107; 7'd86: r = 7'd78; 7'd87: r = 7'd58;
         7'd88: r = 7'd35; 7'd89: r = 7'd63; 7'd90: r = 7'd71; 7'd91: r = 7'd34;
         7'd92: r = 7'd105; 7'd93: r = 7'd64;
         default: r = 7'd0;
      endcase
      xlat = r;
   endfunction

endpackage

@@ rtl/core/tvm_ram.sv @@
`timescale 1ns / 1ps
module tvm_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 59049
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/core/tvm_trit_alu.sv @@
`timescale 1ns / 1ps
module tvm_trit_alu (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        sel_crz,
   input  logic [15:0] acc,
   input  logic [15:0] dval,
   output logic        done,
   output logic [15:0] result
);

   logic [15:0] a_ff, a_in, d_ff, d_in, r_ff, r_in, p_ff, p_in, res_ff, res_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;

   // divide by three through the reciprocal 43691 / 2^17
   function automatic logic [15:0] div3(input logic [15:0] x);
      logic [31:0] prod;
      prod = 32'(x) * 32'd43691;
      div3 = {1'b0, prod[31:17]};
   endfunction

   function automatic logic [1:0] rem3(input logic [15:0] x, input logic [15:0] q);
      logic [15:0] t;
      t = x - {q[14:0], 1'b0} - q;
      rem3 = t[1:0];
   endfunction

   assign done   = done_ff;
   assign result = res_ff;

   // crazy op one trit per cycle; rotate right by one trit is computed combinationally and registered on start
   always_comb begin
      logic [15:0] qa, qd, qr, cterm, rot;
      logic [1:0]  ta, td, tr, c;
      logic [16:0] sum;
      qa = div3(a_ff);
      ta = rem3(a_ff, qa);
      qd = div3(d_ff);
      td = rem3(d_ff, qd);
      case ({td, ta})
         4'b0000: c = 2'd1; 4'b0001: c = 2'd0; 4'b0010: c = 2'd0;
         4'b0100: c = 2'd1; 4'b0101: c = 2'd0; 4'b0110: c = 2'd2;
         4'b1000: c = 2'd2; 4'b1001: c = 2'd2; 4'b1010: c = 2'd1;
         default: c = 2'd0;
      endcase
      cterm = (c == 2'd2) ? {p_ff[14:0], 1'b0} : ((c == 2'd1) ? p_ff : 16'd0);
      qr  = div3(dval);
      tr  = rem3(dval, qr);
      sum = {1'b0, qr} + ((tr == 2'd2) ? {tvm_pkg::TRIT_TOP, 1'b0}
                                       : ((tr == 2'd1) ? {1'b0, tvm_pkg::TRIT_TOP} : 17'd0));
      rot = (sum >= 17'(tvm_pkg::MEM_WORDS)) ? 16'(sum - 17'(tvm_pkg::MEM_WORDS))
                                             : sum[15:0];
      a_in    = a_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      if (start) begin
         if (sel_crz) begin
            a_in   = acc;
            d_in   = dval;
            r_in   = '0;
            p_in   = 16'd1;
            cnt_in = '0;
            run_in = 1'b1;
         end else begin
            res_in  = rot;
            done_in = 1'b1;
         end
      end else if (run_ff) begin
         a_in   = qa;
         d_in   = qd;
         r_in   = r_ff + cterm;
         p_in   = p_ff + {p_ff[14:0], 1'b0};
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(tvm_pkg::TRITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            res_in  = tvm_pkg::mod_mem(r_ff + cterm);
         end
      end
   end

   // hold operands and advance the trit loop
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      d_ff   <= d_in;
      r_ff   <= r_in;
      p_ff   <= p_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

endmodule

@@ rtl/core/ternary_vm_step_unit.sv @@
`timescale 1ns / 1ps
// Channel  Dir  Handshake      Payload
// req      in   valid / stall  tvm_pkg::req_type_type
// rsp      out  valid / stall  tvm_pkg::rsp_type
// csr      in   valid / ready  step_limit[15:0]
// Load, restart, unknown, ignored and step-limit items answer straight from
// idle; an execute item that faults or halts on its fetch answers from the
// fetch state. A full execute is paced by the single memory port: read C,
// read D, write D, reread C, write translated C; rotate and crazy also wait
// in S_ALU for the trit-serial unit. Reset clears acc, C, D, the step count,
// the halt flag and result valid, sets step_limit to 4096, writes no memory.
// A new item enters when idle and the result register is free or being taken.
module ternary_vm_step_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  tvm_pkg::req_type_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output tvm_pkg::rsp_type      rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [15:0]           csr_data
);

   localparam int unsigned AW = $clog2(tvm_pkg::MEM_WORDS);

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_DREAD, S_ALU, S_DWRITE, S_CREAD, S_CXLAT
   } state_type;

   state_type   state_ff;
   logic [15:0] acc_ff, cp_ff, dp_ff, steps_ff, limit_ff;
   logic        halted_ff;
   logic [6:0]  op_ff;
   logic [15:0] inval_ff;
   logic        rsp_valid_ff;
   tvm_pkg::rsp_type rsp_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_data, rd_data, alu_res;
   logic          out_free, take, alu_start, alu_done;

   // opcode (x mod 94) through the reciprocal 44621 / 2^21 on x / 2
   function automatic logic [6:0] op_of(input logic [15:0] x);
      logic [31:0] prod;
      logic [15:0] q, r;
      prod = 32'(x[15:1]) * 32'd44621;
      q = {5'd0, prod[31:21]};
      r = x - 16'(q * 16'd94);
      op_of = r[6:0];
   endfunction

   tvm_ram #(.WIDTH(16), .DEPTH(tvm_pkg::MEM_WORDS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   tvm_trit_alu u_alu (
      .clock, .reset, .start(alu_start), .sel_crz(op_ff == tvm_pkg::OP_CRZ),
      .acc(acc_ff), .dval(rd_data), .done(alu_done), .result(alu_res)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && out_free);
   assign take      = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign alu_start = state_ff == S_DREAD
                      && (op_ff == tvm_pkg::OP_ROT || op_ff == tvm_pkg::OP_CRZ);

   // memory port steering
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = AW'(req_data.addr);
      wr_data = tvm_pkg::mod_mem(req_data.word);
      rd_addr = AW'(cp_ff);
      case (state_ff)
         S_IDLE: begin
            wr_en = take && req_data.req_type == tvm_pkg::REQ_LOAD
                    && req_data.addr < 16'(tvm_pkg::MEM_WORDS);
         end
         S_FETCH:  rd_addr = AW'(dp_ff);
         S_DWRITE: begin
            wr_en   = op_ff == tvm_pkg::OP_ROT || op_ff == tvm_pkg::OP_CRZ;
            wr_addr = AW'(dp_ff);
            wr_data = alu_res;
            rd_addr = AW'(cp_ff);
         end
         S_CXLAT: begin
            wr_en   = rd_data >= 16'd33 && rd_data <= 16'd126;
            wr_addr = AW'(cp_ff);
            wr_data = {9'd0, tvm_pkg::xlat(7'(rd_data - 16'd33))};
         end
         default: ;
      endcase
   end

   // sequencer, registers and result
   always_ff @(posedge clock) begin
      logic [6:0]       op;
      logic             rsp_valid_in;
      tvm_pkg::rsp_type rsp_in;
      op           = op_of(rd_data + cp_ff);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (reset) begin
         state_ff <= S_IDLE; acc_ff <= '0; cp_ff <= '0; dp_ff <= '0;
         steps_ff <= '0; halted_ff <= 1'b0; limit_ff <= 16'd4096;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) limit_ff <= csr_data;
         case (state_ff)
            S_IDLE: if (take) begin
               rsp_in   = '0;
               inval_ff <= tvm_pkg::mod_mem(req_data.in_value);
               case (req_data.req_type)
                  tvm_pkg::REQ_RESTART: begin
                     acc_ff <= '0; cp_ff <= '0; dp_ff <= '0;
                     steps_ff <= '0; halted_ff <= 1'b0; rsp_valid_in = 1'b1;
                  end
                  tvm_pkg::REQ_EXEC: begin
                     if (halted_ff) begin
                        rsp_in.status = tvm_pkg::ST_IGNORED; rsp_valid_in = 1'b1;
                     end else if (steps_ff >= limit_ff) begin
                        rsp_in.status = tvm_pkg::ST_LIMIT; halted_ff <= 1'b1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        state_ff <= S_FETCH;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
            S_FETCH: begin
               if (rd_data < 16'd33 || rd_data > 16'd126) begin
                  rsp_in.status = tvm_pkg::ST_INVALID; halted_ff <= 1'b1;
                  rsp_valid_in = 1'b1; state_ff <= S_IDLE;
               end else if (op == tvm_pkg::OP_HLT) begin
                  rsp_in.status = tvm_pkg::ST_HALTED; halted_ff <= 1'b1;
                  rsp_valid_in = 1'b1; state_ff <= S_IDLE;
               end else begin
                  op_ff    <= op;
                  steps_ff <= steps_ff + 16'd1;
                  state_ff <= S_DREAD;
               end
            end
            S_DREAD: begin
               case (op_ff)
                  tvm_pkg::OP_JMP:  cp_ff <= rd_data;
                  tvm_pkg::OP_MOVD: dp_ff <= rd_data;
                  tvm_pkg::OP_OUT: begin
                     rsp_in.status = tvm_pkg::ST_OUTPUT; rsp_in.out_byte = acc_ff[7:0];
                  end
                  tvm_pkg::OP_IN: begin
                     acc_ff <= inval_ff; rsp_in.input_taken = 1'b1;
                  end
                  default: ;
               endcase
               state_ff <= alu_start ? S_ALU : S_DWRITE;
            end
            S_ALU: if (alu_done) begin
               acc_ff   <= alu_res;
               state_ff <= S_DWRITE;
            end
            S_DWRITE: state_ff <= S_CREAD;
            S_CREAD: state_ff <= S_CXLAT;
            S_CXLAT: begin
               if (rd_data < 16'd33 || rd_data > 16'd126) begin
                  rsp_in.status = tvm_pkg::ST_INVALID; rsp_in.out_byte = '0;
                  halted_ff <= 1'b1;
               end else begin
                  cp_ff <= (cp_ff == 16'(tvm_pkg::MEM_WORDS - 1)) ? '0 : cp_ff + 16'd1;
                  dp_ff <= (dp_ff == 16'(tvm_pkg::MEM_WORDS - 1)) ? '0 : dp_ff + 16'd1;
               end
               rsp_valid_in = 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

endmodule
